### src/nrte_pkg.sv
// Shared constants, types and helper functions for the RMC time extractor.
package nrte_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_E      = 8'h45;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_D      = 8'h44;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_F      = 8'h46;

   localparam int PREFIX_LEN = 6;
   localparam int END_LEN    = 3;
   localparam int TIME_FIRST = 7;
   localparam int TIME_END   = 13;
   localparam int TIME_DIGITS = TIME_END - TIME_FIRST;

   localparam logic [4:0] HOUR_OFFSET_RESET = 5'd8;
   localparam logic [6:0] HOURS_PER_DAY     = 7'd24;

   localparam int TDATA_W = 24;
   localparam int TUSER_W = 2;

   typedef struct packed {
      logic       valid;    // prefix, checksum and time digits good
      logic       is_end;   // token was exactly END
      logic [6:0] hour;     // raw two-digit hour, 0..99
      logic [6:0] minute;
      logic [6:0] second;
   } token_result_type;

   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = CHAR_DOLLAR;
         3'd1:    ch = CHAR_G;
         3'd2:    ch = CHAR_P;
         3'd3:    ch = CHAR_R;
         3'd4:    ch = CHAR_M;
         3'd5:    ch = CHAR_C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] end_char(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0:    ch = CHAR_E;
         2'd1:    ch = CHAR_N;
         2'd2:    ch = CHAR_D;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Bit 4 set means the byte is not an upper-case hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [7:0] diff;
      logic [4:0] v;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         diff = ch - CHAR_ZERO;
         v = {1'b0, diff[3:0]};
      end else if (ch >= CHAR_A && ch <= CHAR_F) begin
         diff = ch - CHAR_A + 8'd10;
         v = {1'b0, diff[3:0]};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage

### src/nrte_token_parser.sv
// Per-token parse state: prefix and END match, checksum, time digit capture.
module nrte_token_parser
   import nrte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       char_byte,
   input  logic             token_last,
   output token_result_type result
);

   typedef enum logic [1:0] {
      PH_BODY,
      PH_HEX_HI,
      PH_HEX_LO,
      PH_DONE
   } phase_type;

   logic [3:0] position_ff, position_in;
   logic       prefix_ff, prefix_in;
   logic       end_ff, end_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] given_ff, given_in;
   logic       bad_ff, bad_in;
   logic [3:0] digit_ff [TIME_DIGITS];
   logic [3:0] digit_in [TIME_DIGITS];

   logic [4:0] hex;
   logic [7:0] dec;
   logic [2:0] digit_idx;
   logic       in_time;

   always_comb begin
      hex         = hex_value(char_byte);
      dec         = char_byte - CHAR_ZERO;
      position_in = position_ff;
      prefix_in   = prefix_ff;
      end_in      = end_ff;
      phase_in    = phase_ff;
      xor_in      = xor_ff;
      given_in    = given_ff;
      bad_in      = bad_ff;
      digit_in    = digit_ff;

      if (position_ff < 4'(PREFIX_LEN) && char_byte != prefix_char(position_ff[2:0]))
         prefix_in = 1'b0;
      if (position_ff >= 4'(END_LEN) || char_byte != end_char(position_ff[1:0]))
         end_in = 1'b0;

      in_time   = position_ff >= 4'(TIME_FIRST) && position_ff < 4'(TIME_END);
      digit_idx = 3'(position_ff - 4'(TIME_FIRST));
      if (in_time) begin
         if (char_byte >= CHAR_ZERO && char_byte <= CHAR_NINE)
            digit_in[digit_idx] = dec[3:0];
         else
            bad_in = 1'b1;
      end

      unique case (phase_ff)
         PH_BODY: begin
            if (char_byte == CHAR_STAR)
               phase_in = PH_HEX_HI;
            else if (position_ff != 4'd0)
               xor_in = xor_ff ^ char_byte;
         end
         PH_HEX_HI, PH_HEX_LO: begin
            if (hex[4])
               bad_in = 1'b1;
            else
               given_in = {given_ff[3:0], hex[3:0]};
            phase_in = (phase_ff == PH_HEX_HI) ? PH_HEX_LO : PH_DONE;
         end
         PH_DONE: ;
      endcase

      if (position_ff < 4'(TIME_END))
         position_in = position_ff + 4'd1;

      result.valid  = prefix_in && phase_in == PH_DONE && !bad_in &&
                      xor_in == given_in && position_in >= 4'(TIME_END);
      result.is_end = end_in && position_in == 4'(END_LEN);
      result.hour   = 7'(digit_in[0]) * 7'd10 + 7'(digit_in[1]);
      result.minute = 7'(digit_in[2]) * 7'd10 + 7'(digit_in[3]);
      result.second = 7'(digit_in[4]) * 7'd10 + 7'(digit_in[5]);
   end

   always_ff @(posedge clock) begin
      if (reset || (step && token_last)) begin
         position_ff <= '0;
         prefix_ff   <= 1'b1;
         end_ff      <= 1'b1;
         phase_ff    <= PH_BODY;
         xor_ff      <= '0;
         given_ff    <= '0;
         bad_ff      <= 1'b0;
         for (int k = 0; k < TIME_DIGITS; k++)
            digit_ff[k] <= '0;
      end else if (step) begin
         position_ff <= position_in;
         prefix_ff   <= prefix_in;
         end_ff      <= end_in;
         phase_ff    <= phase_in;
         xor_ff      <= xor_in;
         given_ff    <= given_in;
         bad_ff      <= bad_in;
         digit_ff    <= digit_in;
      end
   end

endmodule

### src/nrte_time_hold.sv
// Held time, hour offset register and the registered result item.
module nrte_time_hold
   import nrte_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [4:0]           csr_wr_data,
   input  logic                 load,
   input  token_result_type     result,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,
   output logic [TUSER_W-1:0]   rsp_tuser
);

   logic [4:0]         offset_ff;
   logic [4:0]         hour_ff, hour_in;
   logic [6:0]         min_ff, min_in;
   logic [6:0]         sec_ff, sec_in;
   logic               valid_ff, valid_in;
   logic [TDATA_W-1:0] data_ff, data_in;
   logic [TUSER_W-1:0] user_ff, user_in;

   logic [6:0] hour_mod;
   logic [6:0] sum;
   logic [6:0] local_hour;

   always_comb begin
      // raw hour is at most 99, so four steps of 24 cover it
      if (result.hour < HOURS_PER_DAY)
         hour_mod = result.hour;
      else if (result.hour < 7'(2 * HOURS_PER_DAY))
         hour_mod = result.hour - HOURS_PER_DAY;
      else if (result.hour < 7'(3 * HOURS_PER_DAY))
         hour_mod = result.hour - 7'(2 * HOURS_PER_DAY);
      else if (result.hour < 7'(4 * HOURS_PER_DAY))
         hour_mod = result.hour - 7'(3 * HOURS_PER_DAY);
      else
         hour_mod = result.hour - 7'(4 * HOURS_PER_DAY);

      hour_in = hour_ff;
      min_in  = min_ff;
      sec_in  = sec_ff;
      if (result.valid) begin
         hour_in = hour_mod[4:0];
         min_in  = result.minute;
         sec_in  = result.second;
      end

      // held hour < 24 and offset < 32, so the sum stays below 72
      sum = 7'(hour_in) + 7'(offset_ff);
      if (sum < HOURS_PER_DAY)                local_hour = sum;
      else if (sum < 7'(2 * HOURS_PER_DAY))   local_hour = sum - HOURS_PER_DAY;
      else                                    local_hour = sum - 7'(2 * HOURS_PER_DAY);

      out_free = !valid_ff || rsp_tready;
      valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      data_in  = {5'd0, sec_in, min_in, local_hour[4:0]};
      user_in  = {result.is_end, result.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= HOUR_OFFSET_RESET;
         hour_ff   <= '0;
         min_ff    <= '0;
         sec_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en)
            offset_ff <= csr_wr_data;
         if (load) begin
            hour_ff <= hour_in;
            min_ff  <= min_in;
            sec_ff  <= sec_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

### src/nmea_rmc_time_extract_core.sv
// Top level of the NMEA RMC checksum check and time extractor.
//
// Request channel: one byte of a token per item in req_tdata, req_tlast on
// the final byte. Every byte is token content; only tlast ends a token.
// Response channel: one item per token, sent after its last byte. tuser
// carries pass/fail and the END flag, tdata the held time with the hour
// moved by the offset register, modulo 24. csr_wr_en writes the hour offset
// (reset value 8); the user must write it only while the block is idle (not enforced).
//
// Data path: an accepted byte is held in the input register; when it is a
// last byte, its result is then loaded into the response register, which
// drives rsp_tvalid. Throughput is one byte per cycle while no last byte
// waits for the response slot, set by the single input register feeding
// the token parser and result register.
// Reset (synchronous) clears the token state and the held time, sets the
// offset back to 8, and empties both registers. When the receiver stalls the
// response holds; non-last bytes keep flowing, and a last byte waits in the
// input register until the response slot frees, holding req_tready low.
module nmea_rmc_time_extract_core
   import nrte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] char_byte
   input  logic               req_tlast,   // token_last
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [4:0] local_hour, [11:5] held_minute,
                                           // [18:12] held_second, [23:19] zero
   output logic [TUSER_W-1:0] rsp_tuser,   // [0] sentence_valid, [1] end_token
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data  // hour_offset
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             advance;
   logic             out_free;
   token_result_type result;

   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 :
                        (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   nrte_token_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .char_byte  (in_byte_ff),
      .token_last (in_last_ff),
      .result     (result)
   );

   nrte_time_hold u_hold (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .load        (advance && in_last_ff),
      .result      (result),
      .out_free    (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

### src/nrte_checker.sv
// Port-level checks for the RMC time extractor, bound to the top level.
module nrte_checker
   import nrte_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata,
   input logic [TUSER_W-1:0] rsp_tuser
);

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] < 5'd24)
      else $error("local hour out of range");

   // a passing sentence is 13+ bytes, END is three
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("sentence and END flags both set");

endmodule

bind nmea_rmc_time_extract_core nrte_checker u_nrte_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
